@@ hdl/cmt_pkg.sv @@
// Shared codes and constants of the cached mapping table.
// No dependencies; imported by every module of the block but cmt_ram.
package cmt_pkg;

  typedef enum logic [1:0] {
    CMD_PROBE   = 2'd0,
    CMD_GET     = 2'd1,
    CMD_RESERVE = 2'd2,
    CMD_UPDATE  = 2'd3
  } cmd_e;

  localparam logic [1:0] RC_OK        = 2'd0;
  localparam logic [1:0] RC_PRESENT   = 2'd1;
  localparam logic [1:0] RC_NOT_FOUND = 2'd2;

  localparam logic [1:0] ES_ABSENT  = 2'd0;
  localparam logic [1:0] ES_WAITING = 2'd1;
  localparam logic [1:0] ES_VALID   = 2'd2;

  localparam int unsigned CAP_REG_W = 9;
  localparam logic [CAP_REG_W-1:0] CAP_RESET = 9'd256;
  localparam logic REG_CAPACITY = 1'b0;

  typedef enum logic [2:0] {
    ST_CMP = 3'b001,
    ST_IDX = 3'b010,
    ST_EXE = 3'b100
  } back_state_e;

endpackage

@@ hdl/cmt_ram.sv @@
// Generic single write port RAM with registered read.
// No dependencies.
module cmt_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);
  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule

@@ hdl/cmt_front.sv @@
// Front queue: takes requests and holds them for the lookup engine.
// Depends on cmt_pkg.
module cmt_front import cmt_pkg::*; #(
  parameter int unsigned AW = 32,
  parameter int unsigned SW = 8
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push,
  output logic          full,
  input  logic [1:0]    cmd_i,
  input  logic [AW-1:0] logical_page_i,
  input  logic [AW-1:0] physical_page_i,
  input  logic          physical_present_i,
  input  logic [SW-1:0] sector_mask_i,
  input  logic          first_load_i,
  input  logic          replace_mask_i,
  output logic          head_valid_o,
  output logic [2*AW+SW+4:0] head_o,
  input  logic          head_pop_i
);
  localparam int unsigned IT_W = 2*AW + SW + 5;

  logic [IT_W-1:0] buf_q [2];
  logic            wptr_q, rptr_q;
  logic [1:0]      cnt_q;
  logic            do_push, do_pop;

  assign full         = (cnt_q == 2'd2);
  assign head_valid_o = (cnt_q != 2'd0);
  assign head_o       = buf_q[rptr_q];
  assign do_push      = push && !full;
  assign do_pop       = head_pop_i && head_valid_o;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      buf_q[wptr_q] <= {cmd_i, logical_page_i, physical_page_i, physical_present_i,
                        sector_mask_i, first_load_i, replace_mask_i};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= 2'd0;
    end else begin
      if (do_push) wptr_q <= ~wptr_q;
      if (do_pop)  rptr_q <= ~rptr_q;
      cnt_q <= cnt_q + {1'b0, do_push} - {1'b0, do_pop};
    end
  end
endmodule

@@ hdl/cmt_back.sv @@
// Lookup engine: key compare per slot, LRU ranks, slot RAM and result queue.
// Depends on cmt_pkg and cmt_ram.
module cmt_back import cmt_pkg::*; #(
  parameter int unsigned CAPACITY = 256,
  parameter int unsigned AW       = 32,
  parameter int unsigned SW       = 8
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic [CAP_REG_W-1:0] cap_i,
  input  logic                 head_valid_i,
  input  logic [2*AW+SW+4:0]   head_i,
  output logic                 head_pop_o,
  output logic                 empty,
  input  logic                 pop,
  output logic [1:0]           result_code_o,
  output logic [1:0]           entry_state_o,
  output logic                 evicted_o,
  output logic [AW-1:0]        entry_logical_o,
  output logic [AW-1:0]        entry_physical_o,
  output logic                 entry_has_physical_o,
  output logic                 entry_dirty_o,
  output logic [SW-1:0]        entry_mask_o
);
  localparam int unsigned IW    = $clog2(CAPACITY);
  localparam int unsigned CW    = $clog2(CAPACITY + 1);
  localparam int unsigned IT_W  = 2*AW + SW + 5;
  localparam int unsigned RAM_W = 2*AW + SW + 3;
  localparam int unsigned RES_W = 2*AW + SW + 7;

  back_state_e      state_q;
  logic [IT_W-1:0]  item_q;
  logic [CAPACITY-1:0] hit_vec_q, old_vec_q;
  logic [CW-1:0]    occ_q;
  logic [IW-1:0]    slot_q;
  logic             hit_q, evict_q;
  logic [IW-1:0]    hit_rank_q;

  logic [AW-1:0]    key_q  [CAPACITY];
  logic [IW-1:0]    rank_q [CAPACITY];

  // item fields
  logic [1:0]       it_cmd;
  logic [AW-1:0]    it_key, it_phys;
  logic             it_pres, it_first, it_repl;
  logic [SW-1:0]    it_mask;
  assign {it_cmd, it_key, it_phys, it_pres, it_mask, it_first, it_repl} = item_q;

  logic [AW-1:0]    head_key;
  assign head_key = head_i[IT_W-3 -: AW];

  // capacity check
  logic occ_full;
  always_comb begin
    if (occ_q == CW'(CAPACITY)) occ_full = 1'b1;
    else if (cap_i == '0)       occ_full = (occ_q != '0);
    else occ_full = (32'(occ_q) >= 32'(cap_i));
  end

  // index stage
  logic             hit_any, evict_d;
  logic [IW-1:0]    hit_idx, old_idx, hit_rank, slot_d;
  always_comb begin
    hit_idx  = '0;
    old_idx  = '0;
    hit_rank = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      if (hit_vec_q[i]) begin
        hit_idx  = hit_idx | IW'(i);
        hit_rank = hit_rank | rank_q[i];
      end
      if (old_vec_q[i]) old_idx = old_idx | IW'(i);
    end
    hit_any = |hit_vec_q;
    evict_d = (it_cmd == CMD_RESERVE) && !hit_any && occ_full;
    if (hit_any)      slot_d = hit_idx;
    else if (evict_d) slot_d = old_idx;
    else              slot_d = occ_q[IW-1:0];
  end

  // slot RAM: {valid, dirty, has, phys, key, mask}
  logic             ram_we;
  logic [RAM_W-1:0] ram_wdata, ram_rdata;
  logic             r_valid, r_dirty, r_has;
  logic [AW-1:0]    r_phys, r_key;
  logic [SW-1:0]    r_mask;
  assign {r_valid, r_dirty, r_has, r_phys, r_key, r_mask} = ram_rdata;

  cmt_ram #(.WIDTH(RAM_W), .DEPTH(CAPACITY)) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (slot_q),
    .wdata_i (ram_wdata),
    .raddr_i (slot_d),
    .rdata_o (ram_rdata)
  );

  // execute stage
  logic             res_push;
  logic [RES_W-1:0] res_d;
  logic             is_ins, is_get;
  logic [AW-1:0]    n_phys;
  logic [SW-1:0]    n_mask;
  always_comb begin
    res_push  = (state_q == ST_EXE);
    is_ins    = (it_cmd == CMD_RESERVE) && !hit_q;
    is_get    = (it_cmd == CMD_GET) && hit_q;
    n_phys    = it_pres ? it_phys : '0;
    n_mask    = it_repl ? it_mask : (r_mask | it_mask);
    ram_we    = 1'b0;
    ram_wdata = '0;
    res_d     = '0;
    if (it_cmd == CMD_RESERVE) begin
      if (hit_q) begin
        res_d = {RC_PRESENT, (r_valid ? ES_VALID : ES_WAITING), 1'b0,
                 r_key, r_phys, r_has, r_dirty, r_mask};
      end else begin
        if (evict_q) begin
          res_d = {RC_OK, ES_WAITING, 1'b1, r_key, r_phys, r_has, r_dirty, r_mask};
        end else begin
          res_d = {RC_OK, ES_WAITING, 1'b0, it_key, {AW{1'b0}}, 1'b0, 1'b0,
                   {SW{1'b0}}};
        end
        ram_we    = res_push;
        ram_wdata = {3'b000, {AW{1'b0}}, it_key, {SW{1'b0}}};
      end
    end else if (!hit_q) begin
      res_d = {RC_NOT_FOUND, ES_ABSENT, 1'b0, {AW{1'b0}}, {AW{1'b0}}, 1'b0, 1'b0,
               {SW{1'b0}}};
    end else if (it_cmd == CMD_UPDATE) begin
      res_d     = {RC_OK, ES_VALID, 1'b0, r_key, n_phys, it_pres, !it_first, n_mask};
      ram_we    = res_push;
      ram_wdata = {1'b1, !it_first, it_pres, n_phys, r_key, n_mask};
    end else begin
      res_d = {RC_OK, (r_valid ? ES_VALID : ES_WAITING), 1'b0,
               r_key, r_phys, r_has, r_dirty, r_mask};
    end
  end

  // result queue
  logic [RES_W-1:0] oq_q [2];
  logic             owptr_q, orptr_q;
  logic [1:0]       ocnt_q;
  logic             res_pop;
  assign empty   = (ocnt_q == 2'd0);
  assign res_pop = pop && !empty;
  assign {result_code_o, entry_state_o, evicted_o, entry_logical_o, entry_physical_o,
          entry_has_physical_o, entry_dirty_o, entry_mask_o} = oq_q[orptr_q];

  assign head_pop_o = (state_q == ST_CMP) && head_valid_i && (ocnt_q != 2'd2);

  always_ff @(posedge clk_i) begin
    if (res_push) oq_q[owptr_q] <= res_d;
  end

  // per-slot compare and rank cells
  for (genvar g = 0; g < CAPACITY; g++) begin : g_slot
    logic occupied;
    assign occupied = (CW'(g) < occ_q);
    always_ff @(posedge clk_i) begin
      if (head_pop_o) begin
        hit_vec_q[g] <= occupied && (key_q[g] == head_key);
        old_vec_q[g] <= occupied && (rank_q[g] == IW'(occ_q - 1'b1));
      end
      if (res_push && is_ins) begin
        if (slot_q == IW'(g)) begin
          rank_q[g] <= '0;
          key_q[g]  <= it_key;
        end else if (occupied) begin
          rank_q[g] <= rank_q[g] + 1'b1;
        end
      end else if (res_push && is_get) begin
        if (slot_q == IW'(g)) rank_q[g] <= '0;
        else if (occupied && (rank_q[g] < hit_rank_q)) rank_q[g] <= rank_q[g] + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (head_pop_o) item_q <= head_i;
    if (state_q == ST_IDX) begin
      slot_q     <= slot_d;
      hit_q      <= hit_any;
      evict_q    <= evict_d;
      hit_rank_q <= hit_rank;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CMP;
      occ_q   <= '0;
      owptr_q <= 1'b0;
      orptr_q <= 1'b0;
      ocnt_q  <= 2'd0;
    end else begin
      case (state_q)
        ST_CMP:  if (head_pop_o) state_q <= ST_IDX;
        ST_IDX:  state_q <= ST_EXE;
        ST_EXE:  state_q <= ST_CMP;
        default: state_q <= ST_CMP;
      endcase
      if (res_push && is_ins && !evict_q) occ_q <= occ_q + 1'b1;
      if (res_push) owptr_q <= ~owptr_q;
      if (res_pop)  orptr_q <= ~orptr_q;
      ocnt_q <= ocnt_q + {1'b0, res_push} - {1'b0, res_pop};
    end
  end
endmodule

@@ hdl/cached_mapping_table_lru_core.sv @@
// Cached mapping table with LRU replacement: register port and top level.
// Depends on cmt_pkg, cmt_front and cmt_back.
//
// Requests enter through push/full and results leave through empty/pop;
// both sides behave as queues. Every request gives exactly one result, in
// request order. In the lookup engine a request passes through ST_CMP,
// which compares the key against every slot and finds the oldest slot,
// ST_IDX, which encodes the slot index and reads the slot RAM, and ST_EXE,
// which writes back and queues the result. One request is in the engine at
// a time: it takes no new request until it has queued the last result.
// A two-entry queue in front and a two-entry result queue behind let
// either side stall; when the result queue is full the engine holds and
// the front queue fills, then full rises.
// Reset empties the table and both queues and sets capacity_in_use to
// 256; no clearing pass is needed. capacity_in_use is written through the
// APB port at byte address 0; the user must write it only while the block
// is idle, which the block itself does not enforce.
module cached_mapping_table_lru_core import cmt_pkg::*; #(
  parameter int unsigned CAPACITY      = 256,
  parameter int unsigned SECTOR_COUNT  = 8,
  parameter int unsigned ADDRESS_WIDTH = 32
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [2:0]               paddr,
  input  logic [31:0]              pwdata,
  output logic [31:0]              prdata,
  output logic                     pready,
  input  logic                     push,
  output logic                     full,
  input  logic [1:0]               cmd_i,
  input  logic [ADDRESS_WIDTH-1:0] logical_page_i,
  input  logic [ADDRESS_WIDTH-1:0] physical_page_i,
  input  logic                     physical_present_i,
  input  logic [SECTOR_COUNT-1:0]  sector_mask_i,
  input  logic                     first_load_i,
  input  logic                     replace_mask_i,
  output logic                     empty,
  input  logic                     pop,
  output logic [1:0]               result_code_o,
  output logic [1:0]               entry_state_o,
  output logic                     evicted_o,
  output logic [ADDRESS_WIDTH-1:0] entry_logical_o,
  output logic [ADDRESS_WIDTH-1:0] entry_physical_o,
  output logic                     entry_has_physical_o,
  output logic                     entry_dirty_o,
  output logic [SECTOR_COUNT-1:0]  entry_mask_o
);
  localparam int unsigned AW = ADDRESS_WIDTH;
  localparam int unsigned SW = SECTOR_COUNT;

  logic [CAP_REG_W-1:0] cap_q;
  logic                 head_valid, head_pop;
  logic [2*AW+SW+4:0]   head;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_CAPACITY) ? {{(32-CAP_REG_W){1'b0}}, cap_q} : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q <= CAP_RESET;
    end else if (psel && penable && pwrite && (paddr[2] == REG_CAPACITY)) begin
      cap_q <= pwdata[CAP_REG_W-1:0];
    end
  end

  cmt_front #(.AW(AW), .SW(SW)) u_front (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .push               (push),
    .full               (full),
    .cmd_i              (cmd_i),
    .logical_page_i     (logical_page_i),
    .physical_page_i    (physical_page_i),
    .physical_present_i (physical_present_i),
    .sector_mask_i      (sector_mask_i),
    .first_load_i       (first_load_i),
    .replace_mask_i     (replace_mask_i),
    .head_valid_o       (head_valid),
    .head_o             (head),
    .head_pop_i         (head_pop)
  );

  cmt_back #(.CAPACITY(CAPACITY), .AW(AW), .SW(SW)) u_back (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .cap_i                (cap_q),
    .head_valid_i         (head_valid),
    .head_i               (head),
    .head_pop_o           (head_pop),
    .empty                (empty),
    .pop                  (pop),
    .result_code_o        (result_code_o),
    .entry_state_o        (entry_state_o),
    .evicted_o            (evicted_o),
    .entry_logical_o      (entry_logical_o),
    .entry_physical_o     (entry_physical_o),
    .entry_has_physical_o (entry_has_physical_o),
    .entry_dirty_o        (entry_dirty_o),
    .entry_mask_o         (entry_mask_o)
  );
endmodule

@@ hdl/cmt_checker.sv @@
// Port-level checks on the result channel of the mapping table.
// Depends on cmt_pkg; bound to cached_mapping_table_lru_core.
module cmt_checker import cmt_pkg::*; #(
  parameter int unsigned AW = 32
) (
  input logic          clk_i,
  input logic          rst_ni,
  input logic          empty,
  input logic          pop,
  input logic [1:0]    result_code_o,
  input logic [1:0]    entry_state_o,
  input logic          evicted_o,
  input logic [AW-1:0] entry_physical_o,
  input logic          entry_has_physical_o
);
  a_not_found_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && result_code_o == RC_NOT_FOUND) |-> (entry_state_o == ES_ABSENT && !evicted_o))
    else $error("not-found result carries entry data");

  a_evict_is_insert: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && evicted_o) |-> (result_code_o == RC_OK && entry_state_o == ES_WAITING))
    else $error("eviction reported on a failed reserve");

  a_no_page_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !entry_has_physical_o) |-> (entry_physical_o == '0))
    else $error("physical page shown without present flag");

  a_code_known: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> (result_code_o == RC_OK || result_code_o == RC_PRESENT ||
                result_code_o == RC_NOT_FOUND))
    else $error("undefined result code");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> !empty)
    else $error("result withdrawn without pop");
endmodule

bind cached_mapping_table_lru_core cmt_checker #(.AW(ADDRESS_WIDTH)) u_cmt_checker (
  .clk_i                (clk_i),
  .rst_ni               (rst_ni),
  .empty                (empty),
  .pop                  (pop),
  .result_code_o        (result_code_o),
  .entry_state_o        (entry_state_o),
  .evicted_o            (evicted_o),
  .entry_physical_o     (entry_physical_o),
  .entry_has_physical_o (entry_has_physical_o)
);

@@ tb/tb_cached_mapping_table_lru_core.sv @@
// Self-checking testbench for cached_mapping_table_lru_core.
// Drives lookup requests through the queue ports, predicts each result with an
// LRU table model and compares; depends on cmt_pkg and the block only.
`timescale 1ns / 1ps

module tb_cached_mapping_table_lru_core;
  import cmt_pkg::*;

  localparam int CAP = 256;
  localparam int WATCHDOG_LIMIT = 20000;

  typedef struct packed {
    logic [1:0]  code;
    logic [1:0]  state;
    logic        evicted;
    logic [31:0] lpage;
    logic [31:0] ppage;
    logic        has_phys;
    logic        dirty;
    logic [7:0]  mask;
  } lookup_result_t;

  typedef struct packed {
    cmd_e        cmd;
    logic [31:0] lpage;
    logic [31:0] ppage;
    logic        present;
    logic [7:0]  smask;
    logic        first;
    logic        replace;
  } request_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [2:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;
  logic push = 1'b0;
  logic full;
  logic pop = 1'b0;
  logic empty;
  logic [1:0] cmd_i = '0;
  logic [31:0] logical_page_i = '0, physical_page_i = '0;
  logic physical_present_i = 1'b0, first_load_i = 1'b0, replace_mask_i = 1'b0;
  logic [7:0] sector_mask_i = '0;
  logic [1:0] result_code_o, entry_state_o;
  logic evicted_o, entry_has_physical_o, entry_dirty_o;
  logic [31:0] entry_logical_o, entry_physical_o;
  logic [7:0] entry_mask_o;

  always #5 clk_i = ~clk_i;

  cached_mapping_table_lru_core dut (.*);

  // table shadow
  logic [31:0] tbl_key [CAP];
  logic [32:0] tbl_phys [CAP];
  logic [1:0]  tbl_status [CAP];
  logic        tbl_dirty [CAP];
  logic [7:0]  tbl_mask [CAP];
  int unsigned tbl_rank [CAP];
  int unsigned occupancy;
  int unsigned cap_reg;

  lookup_result_t pending_results[$];
  int errors = 0;
  int n_results = 0, n_evictions = 0, n_requests = 0;
  int idle_cycles = 0;
  int send_idle_pct = 0, recv_stall_pct = 0;
  bit hold_off = 1'b0;

  function automatic lookup_result_t slot_contents(int s);
    lookup_result_t r = '0;
    r.lpage = tbl_key[s];
    r.has_phys = tbl_phys[s][32];
    r.ppage = tbl_phys[s][32] ? tbl_phys[s][31:0] : 32'd0;
    r.dirty = tbl_dirty[s];
    r.mask = tbl_mask[s];
    return r;
  endfunction

  function automatic lookup_result_t predict_lookup(request_t q);
    lookup_result_t r = '0;
    int hit = -1, victim = -1;
    int unsigned eff, rk;
    for (int i = 0; i < CAP; i++)
      if (hit < 0 && tbl_status[i] != ES_ABSENT && tbl_key[i] == q.lpage) hit = i;
    if (q.cmd == CMD_RESERVE) begin
      if (hit >= 0) begin
        r = slot_contents(hit);
        r.code = RC_PRESENT;
        r.state = tbl_status[hit];
        return r;
      end
      r.code = RC_OK;
      r.state = ES_WAITING;
      r.lpage = q.lpage;
      eff = (cap_reg == 0) ? 1 : (cap_reg > CAP ? CAP : cap_reg);
      if (occupancy >= eff && occupancy > 0) begin
        for (int i = 0; i < CAP; i++)
          if (victim < 0 && tbl_status[i] != ES_ABSENT && tbl_rank[i] == occupancy - 1)
            victim = i;
        if (victim >= 0) begin
          r = slot_contents(victim);
          r.code = RC_OK;
          r.state = ES_WAITING;
          r.evicted = 1'b1;
          tbl_status[victim] = ES_ABSENT;
          occupancy--;
        end
      end
      if (victim < 0)
        for (int i = 0; i < CAP; i++)
          if (victim < 0 && tbl_status[i] == ES_ABSENT) victim = i;
      for (int i = 0; i < CAP; i++)
        if (tbl_status[i] != ES_ABSENT) tbl_rank[i]++;
      tbl_key[victim] = q.lpage;
      tbl_phys[victim] = '0;
      tbl_status[victim] = ES_WAITING;
      tbl_dirty[victim] = 1'b0;
      tbl_mask[victim] = '0;
      tbl_rank[victim] = 0;
      occupancy++;
      return r;
    end
    if (hit < 0) begin
      r.code = RC_NOT_FOUND;
      return r;
    end
    if (q.cmd == CMD_GET) begin
      rk = tbl_rank[hit];
      for (int i = 0; i < CAP; i++)
        if (tbl_status[i] != ES_ABSENT && tbl_rank[i] < rk) tbl_rank[i]++;
      tbl_rank[hit] = 0;
    end else if (q.cmd == CMD_UPDATE) begin
      tbl_status[hit] = ES_VALID;
      tbl_phys[hit] = q.present ? {1'b1, q.ppage} : 33'd0;
      tbl_dirty[hit] = ~q.first;
      tbl_mask[hit] = q.replace ? q.smask : (tbl_mask[hit] | q.smask);
    end
    r = slot_contents(hit);
    r.code = RC_OK;
    r.state = tbl_status[hit];
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("ERROR t=%0t result %0d: %s got %0h expected %0h", $time, n_results,
             what, got, want);
    errors++;
  endtask

  // result side: sample at rising edge
  always @(posedge clk_i) begin
    if (rst_ni && pop && !empty) begin
      lookup_result_t w;
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected result", 0, 0);
      end else begin
        w = pending_results.pop_front();
        if (result_code_o !== w.code)
          report_mismatch("result_code", 32'(result_code_o), 32'(w.code));
        if (entry_state_o !== w.state)
          report_mismatch("entry_state", 32'(entry_state_o), 32'(w.state));
        if (evicted_o !== w.evicted)
          report_mismatch("evicted", 32'(evicted_o), 32'(w.evicted));
        if (entry_logical_o !== w.lpage)
          report_mismatch("entry_logical", entry_logical_o, w.lpage);
        if (entry_physical_o !== w.ppage)
          report_mismatch("entry_physical", entry_physical_o, w.ppage);
        if (entry_has_physical_o !== w.has_phys)
          report_mismatch("entry_has_physical", 32'(entry_has_physical_o),
                          32'(w.has_phys));
        if (entry_dirty_o !== w.dirty)
          report_mismatch("entry_dirty", 32'(entry_dirty_o), 32'(w.dirty));
        if (entry_mask_o !== w.mask)
          report_mismatch("entry_mask", 32'(entry_mask_o), 32'(w.mask));
        if (w.evicted) n_evictions++;
      end
      n_results++;
    end
  end

  // receiver stalls, changing at the falling edge
  always @(negedge clk_i)
    pop <= !hold_off && ($urandom_range(99) >= recv_stall_pct);

  // watchdog: cycles with nothing accepted
  always @(posedge clk_i) begin
    if ((push && !full) || (pop && !empty) || !rst_ni) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Watchdog expired with %0d results outstanding", pending_results.size());
      $display("FAILURE");
      $finish;
    end
  end

  // called at a falling edge; leaves push high for a following request
  task automatic send_request(request_t q);
    while ($urandom_range(99) < send_idle_pct) begin
      push <= 1'b0;
      @(negedge clk_i);
    end
    push <= 1'b1;
    cmd_i <= q.cmd;
    logical_page_i <= q.lpage;
    physical_page_i <= q.ppage;
    physical_present_i <= q.present;
    sector_mask_i <= q.smask;
    first_load_i <= q.first;
    replace_mask_i <= q.replace;
    @(posedge clk_i);
    while (full) @(posedge clk_i);
    pending_results.push_back(predict_lookup(q));
    n_requests++;
    @(negedge clk_i);
  endtask

  task automatic write_capacity(logic [31:0] value);
    push <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk_i);
    repeat (8) @(negedge clk_i);
    psel <= 1'b1;
    pwrite <= 1'b1;
    paddr <= 3'(4 * REG_CAPACITY);
    pwdata <= value;
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    cap_reg = 32'(value[8:0]);
    @(negedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  // random request; keys drawn from a small pool so hits and evictions happen
  function automatic request_t random_request(int unsigned pool);
    request_t q;
    int unsigned k = $urandom_range(pool - 1);
    q.cmd = cmd_e'($urandom_range(3));
    if ($urandom_range(99) < 5) q.lpage = $urandom();
    else q.lpage = (k[0] ? 32'hFFFF_0000 : 32'h0) ^ k;
    q.ppage = $urandom();
    q.present = 1'($urandom_range(1));
    q.smask = 8'($urandom_range(255));
    q.first = 1'($urandom_range(1));
    q.replace = 1'($urandom_range(1));
    return q;
  endfunction

  typedef struct {
    request_t q;
    bit checked;
    lookup_result_t r;
  } directed_row_t;

  directed_row_t directed_rows[$];

  initial begin
    request_t q;
    lookup_result_t nf, dr;
    int unsigned caps[5] = '{256, 1, 0, 511, 4};
    int unsigned pools[5] = '{400, 3, 2, 600, 8};
    int unsigned idle_s[4] = '{0, 80, 0, 9};
    int unsigned idle_r[4] = '{0, 0, 80, 9};

    occupancy = 0;
    cap_reg = CAP;
    for (int i = 0; i < CAP; i++) begin
      tbl_status[i] = ES_ABSENT;
      tbl_dirty[i] = 1'b0;
      tbl_rank[i] = 0;
      tbl_key[i] = '0;
      tbl_phys[i] = '0;
      tbl_mask[i] = '0;
    end
    repeat (7) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // directed table: typed expectations where obvious, else predictor
    nf = '0;
    nf.code = RC_NOT_FOUND;
    directed_rows.push_back('{'{CMD_PROBE, 32'h0, 32'h0, 1'b0, 8'h00, 1'b0, 1'b0}, 1, nf});
    directed_rows.push_back('{'{CMD_GET, 32'hFFFF_FFFF, 32'h0, 1'b0, 8'h0, 1'b0, 1'b0}, 1, nf});
    directed_rows.push_back('{'{CMD_UPDATE, 32'h1, 32'hFFFF_FFFF, 1'b1, 8'hFF, 1'b0, 1'b1}, 1, nf});
    dr = '0;
    dr.state = ES_WAITING;
    dr.lpage = 32'hFFFF_FFFF;
    directed_rows.push_back('{'{CMD_RESERVE, 32'hFFFF_FFFF, 32'h0, 1'b0, 8'h0, 1'b0, 1'b0}, 1, dr});
    dr.code = RC_PRESENT;
    directed_rows.push_back('{'{CMD_RESERVE, 32'hFFFF_FFFF, 32'h5, 1'b1, 8'hFF, 1'b1, 1'b1}, 1, dr});
    directed_rows.push_back('{'{CMD_RESERVE, 32'h0, 32'h0, 1'b0, 8'h0, 1'b0, 1'b0}, 0, '0});
    directed_rows.push_back('{'{CMD_GET, 32'h0, 32'h0, 1'b0, 8'h0, 1'b0, 1'b0}, 0, '0});
    directed_rows.push_back('{'{CMD_UPDATE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 8'h0F, 1'b0, 1'b1},
                              0, '0});
    directed_rows.push_back('{'{CMD_UPDATE, 32'hFFFF_FFFF, 32'h0, 1'b1, 8'hF0, 1'b1, 1'b0}, 0, '0});
    directed_rows.push_back('{'{CMD_UPDATE, 32'h0, 32'hA5A5_5A5A, 1'b0, 8'hFF, 1'b0, 1'b0}, 0, '0});
    directed_rows.push_back('{'{CMD_PROBE, 32'hFFFF_FFFF, 32'h0, 1'b0, 8'h0, 1'b0, 1'b0}, 0, '0});
    directed_rows.push_back('{'{CMD_PROBE, 32'h0, 32'h0, 1'b0, 8'h0, 1'b0, 1'b0}, 0, '0});
    directed_rows.push_back('{'{CMD_RESERVE, 32'h0, 32'h0, 1'b0, 8'h0, 1'b0, 1'b0}, 0, '0});

    foreach (directed_rows[i]) begin
      lookup_result_t typed;
      send_request(directed_rows[i].q);
      typed = pending_results[pending_results.size() - 1];
      if (directed_rows[i].checked && typed !== directed_rows[i].r)
        report_mismatch("directed prediction", i, 0);
    end

    // lowered capacity: evict in LRU order, with a get refreshing recency
    write_capacity(2);
    for (int i = 0; i < 6; i++) begin
      q = random_request(4);
      q.cmd = (i == 3) ? CMD_GET : CMD_RESERVE;
      q.lpage = 32'h100 + i;
      if (i == 3) q.lpage = 32'h101;
      send_request(q);
    end

    // random phases across capacity settings and idle patterns
    for (int c = 0; c < 5; c++) begin
      write_capacity(caps[c]);
      for (int p = 0; p < 4; p++) begin
        send_idle_pct = idle_s[p];
        recv_stall_pct = idle_r[p];
        for (int n = 0; n < 90; n++) begin
          q = random_request(pools[c]);
          if ($urandom_range(99) < 40) q.cmd = CMD_RESERVE;
          send_request(q);
        end
      end
    end

    // long hold-off on the result side while requests keep coming
    send_idle_pct = 0;
    recv_stall_pct = 0;
    fork
      begin
        hold_off = 1'b1;
        repeat (60) @(negedge clk_i);
        hold_off = 1'b0;
      end
      for (int n = 0; n < 20; n++) send_request(random_request(8));
    join
    push <= 1'b0;

    while (pending_results.size() != 0) @(negedge clk_i);
    repeat (10) @(negedge clk_i);
    $display("Sent %0d requests, checked %0d results, %0d with eviction", n_requests,
             n_results, n_evictions);
    $display("Capacities 256, 2, 1, 0, 511 and 4 under four idle patterns");
    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("%0d mismatches", errors);
      $display("FAILURE");
    end
    $finish;
  end

endmodule

@@ cached_mapping_table_lru_core.f @@
hdl/cmt_pkg.sv
hdl/cmt_ram.sv
hdl/cmt_front.sv
hdl/cmt_back.sv
hdl/cached_mapping_table_lru_core.sv
hdl/cmt_checker.sv
tb/tb_cached_mapping_table_lru_core.sv
